// ===== rtl/endstop_oversample_trigger_unit_assert.svh =====
// Assertion macros for the endstop oversample trigger unit.
`ifndef ENDSTOP_OVERSAMPLE_TRIGGER_UNIT_ASSERT_SVH
`define ENDSTOP_OVERSAMPLE_TRIGGER_UNIT_ASSERT_SVH

// A condition that must hold now implies a consequence in the same cycle.
`define EOT_ASSERT_SAME(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("eot: same-cycle check failed");

// A condition that must hold now implies a consequence in the next cycle.
`define EOT_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("eot: next-cycle check failed");

`endif

// ===== rtl/eot_pkg.sv =====
// Package with the request codes and register map of the endstop oversample trigger unit.
package eot_pkg;

   localparam int unsigned TIME_WIDTH  = 32;
   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      REQ_TICK    = 2'd0,
      REQ_ARM     = 2'd1,
      REQ_RECOVER = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_SAMPLE_INTERVAL = 3'd0,
      CSR_SAMPLE_TOTAL    = 3'd1,
      CSR_REST_INTERVAL   = 3'd2,
      CSR_ACTIVE_LEVEL    = 3'd3,
      CSR_REASON_CODE     = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/endstop_oversample_trigger_unit.sv =====
// Top level of the endstop oversample trigger unit: homing endstop qualifier.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type, now_clock, pin_level, start_clock
//   rsp      out        rsp_valid/rsp_stall   triggered, cause_code, homing, resume_time,
//                                             pin_now
//   csr      in         APB-style write/read  registers at byte address 4*index
//
// Each beat is evaluated in the cycle it is accepted and its result appears in the
// output register in the next cycle; one beat per cycle is sustained while rsp_stall is low.
// A new beat is taken whenever the output register is empty or drained in that cycle.
// Synchronous reset clears the CSR and control state and the output valid, but not the response payload.
module endstop_oversample_trigger_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_now_clock,
   input  logic        req_pin_level,
   input  logic [31:0] req_start_clock,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_triggered,
   output logic [7:0]  rsp_cause_code,
   output logic        rsp_homing,
   output logic [31:0] rsp_resume_time,
   output logic        rsp_pin_now,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [eot_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [eot_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [eot_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic        csr_pready
);

   logic [eot_pkg::TIME_WIDTH-1:0]  sample_interval_ff, sample_interval_in;
   logic [eot_pkg::COUNT_WIDTH-1:0] sample_total_ff, sample_total_in;
   logic [eot_pkg::TIME_WIDTH-1:0]  rest_interval_ff, rest_interval_in;
   logic                            active_level_ff, active_level_in;
   logic [eot_pkg::COUNT_WIDTH-1:0] reason_code_ff, reason_code_in;

   logic [eot_pkg::TIME_WIDTH-1:0]  wake_time_ff, wake_time_in;
   logic [eot_pkg::TIME_WIDTH-1:0]  saved_wake_ff, saved_wake_in;
   logic [eot_pkg::COUNT_WIDTH-1:0] matches_left_ff, matches_left_in;
   logic                            homing_flag_ff, homing_flag_in;
   logic                            oversampling_ff, oversampling_in;
   logic                            timer_running_ff, timer_running_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_triggered_ff, rsp_triggered_in;
   logic [eot_pkg::COUNT_WIDTH-1:0] rsp_reason_ff, rsp_reason_in;
   logic                            rsp_homing_ff, rsp_homing_in;
   logic [eot_pkg::TIME_WIDTH-1:0]  rsp_resume_time_ff, rsp_resume_time_in;
   logic                            rsp_pin_ff, rsp_pin_in;

   logic                            req_accept;
   logic                            csr_write;
   eot_pkg::csr_index_type          csr_index;
   eot_pkg::req_code_type           req_code;
   logic [eot_pkg::TIME_WIDTH-1:0]  elapsed;
   logic [eot_pkg::TIME_WIDTH-1:0]  rest_next;
   logic [eot_pkg::TIME_WIDTH-1:0]  sample_next;
   logic [eot_pkg::COUNT_WIDTH-1:0] left_next;
   logic                            pin_match;
   logic                            fired;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = eot_pkg::csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         eot_pkg::CSR_SAMPLE_INTERVAL: csr_prdata = sample_interval_ff;
         eot_pkg::CSR_SAMPLE_TOTAL:    csr_prdata = {24'd0, sample_total_ff};
         eot_pkg::CSR_REST_INTERVAL:   csr_prdata = rest_interval_ff;
         eot_pkg::CSR_ACTIVE_LEVEL:    csr_prdata = {31'd0, active_level_ff};
         eot_pkg::CSR_REASON_CODE:     csr_prdata = {24'd0, reason_code_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_comb begin
      sample_interval_in = sample_interval_ff;
      sample_total_in    = sample_total_ff;
      rest_interval_in   = rest_interval_ff;
      active_level_in    = active_level_ff;
      reason_code_in     = reason_code_ff;
      if (csr_write) begin
         unique case (csr_index)
            eot_pkg::CSR_SAMPLE_INTERVAL: sample_interval_in = csr_pwdata;
            eot_pkg::CSR_SAMPLE_TOTAL:    sample_total_in    = csr_pwdata[7:0];
            eot_pkg::CSR_REST_INTERVAL:   rest_interval_in   = csr_pwdata;
            eot_pkg::CSR_ACTIVE_LEVEL:    active_level_in    = csr_pwdata[0];
            eot_pkg::CSR_REASON_CODE:     reason_code_in     = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_code    = eot_pkg::req_code_type'(req_type);
   assign elapsed     = req_now_clock - wake_time_ff;
   assign rest_next   = wake_time_ff + rest_interval_ff;
   assign sample_next = wake_time_ff + sample_interval_ff;
   assign left_next   = matches_left_ff - 8'd1;
   assign pin_match   = (req_pin_level == active_level_ff);

   always_comb begin
      wake_time_in     = wake_time_ff;
      saved_wake_in    = saved_wake_ff;
      matches_left_in  = matches_left_ff;
      homing_flag_in   = homing_flag_ff;
      oversampling_in  = oversampling_ff;
      timer_running_in = timer_running_ff;
      fired            = 1'b0;
      if (req_accept) begin
         case (req_code)
            eot_pkg::REQ_TICK: begin
               if (timer_running_ff && !elapsed[31]) begin
                  if (!oversampling_ff && !pin_match) begin
                     wake_time_in = rest_next;
                  end else if (!pin_match) begin
                     oversampling_in = 1'b0;
                     wake_time_in    = saved_wake_ff;
                     matches_left_in = sample_total_ff;
                  end else begin
                     if (!oversampling_ff) begin
                        saved_wake_in   = rest_next;
                        oversampling_in = 1'b1;
                     end
                     if (left_next == '0) begin
                        timer_running_in = 1'b0;
                        fired            = 1'b1;
                     end else begin
                        matches_left_in = left_next;
                        wake_time_in    = sample_next;
                     end
                  end
               end
            end
            eot_pkg::REQ_ARM: begin
               timer_running_in = 1'b0;
               wake_time_in     = req_start_clock;
               if (sample_total_ff == '0) begin
                  homing_flag_in = 1'b0;
               end else begin
                  oversampling_in  = 1'b0;
                  matches_left_in  = sample_total_ff;
                  homing_flag_in   = 1'b1;
                  timer_running_in = 1'b1;
               end
            end
            eot_pkg::REQ_RECOVER: begin
               timer_running_in = 1'b0;
               matches_left_in  = sample_total_ff;
               homing_flag_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in       = rsp_valid_ff & rsp_stall;
      rsp_triggered_in   = rsp_triggered_ff;
      rsp_reason_in      = rsp_reason_ff;
      rsp_homing_in      = rsp_homing_ff;
      rsp_resume_time_in = rsp_resume_time_ff;
      rsp_pin_in         = rsp_pin_ff;
      if (req_accept) begin
         rsp_valid_in       = 1'b1;
         rsp_triggered_in   = fired;
         rsp_reason_in      = fired ? reason_code_ff : '0;
         rsp_homing_in      = homing_flag_in;
         rsp_resume_time_in = saved_wake_in;
         rsp_pin_in         = req_pin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_interval_ff <= '0;
         sample_total_ff    <= '0;
         rest_interval_ff   <= '0;
         active_level_ff    <= 1'b0;
         reason_code_ff     <= '0;
         wake_time_ff       <= '0;
         saved_wake_ff      <= '0;
         matches_left_ff    <= '0;
         homing_flag_ff     <= 1'b0;
         oversampling_ff    <= 1'b0;
         timer_running_ff   <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         sample_interval_ff <= sample_interval_in;
         sample_total_ff    <= sample_total_in;
         rest_interval_ff   <= rest_interval_in;
         active_level_ff    <= active_level_in;
         reason_code_ff     <= reason_code_in;
         wake_time_ff       <= wake_time_in;
         saved_wake_ff      <= saved_wake_in;
         matches_left_ff    <= matches_left_in;
         homing_flag_ff     <= homing_flag_in;
         oversampling_ff    <= oversampling_in;
         timer_running_ff   <= timer_running_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_triggered_ff   <= rsp_triggered_in;
      rsp_reason_ff      <= rsp_reason_in;
      rsp_homing_ff      <= rsp_homing_in;
      rsp_resume_time_ff <= rsp_resume_time_in;
      rsp_pin_ff         <= rsp_pin_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_triggered   = rsp_triggered_ff;
   assign rsp_cause_code  = rsp_reason_ff;
   assign rsp_homing      = rsp_homing_ff;
   assign rsp_resume_time = rsp_resume_time_ff;
   assign rsp_pin_now     = rsp_pin_ff;

`include "endstop_oversample_trigger_unit_assert.svh"

   // The timer only runs while homing is armed.
   `EOT_ASSERT_SAME(a_running_needs_homing, timer_running_ff, homing_flag_ff)
   // A delivered trigger always reports an armed homing flag.
   `EOT_ASSERT_SAME(a_trigger_reports_homing, rsp_valid_ff && rsp_triggered_ff, rsp_homing_ff)
   // Firing the trigger stops the timer.
   `EOT_ASSERT_NEXT(a_fire_stops_timer, fired, !timer_running_ff && rsp_triggered_ff)

endmodule
